// ===== design/sdspi_pkg.sv =====
package sdspi_pkg;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_READY = 3'd1,
      PH_SKIP  = 3'd2,
      PH_RESP  = 3'd3,
      PH_EXTRA = 3'd4,
      PH_SEND  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      RK_R1  = 3'd0,
      RK_R1B = 3'd1,
      RK_R2  = 3'd2,
      RK_R3  = 3'd3,
      RK_R7  = 3'd4
   } kind_type;

   localparam logic [1:0] OC_OK    = 2'd0;
   localparam logic [1:0] OC_READY = 2'd1;
   localparam logic [1:0] OC_RESP  = 2'd2;

   localparam logic       CSR_CRC_ENABLE  = 1'b0;
   localparam logic       CSR_RETRY_LIMIT = 1'b1;
   localparam int         CSR_WIDTH       = 24;
   localparam logic [23:0] RETRY_RESET    = 24'd65535;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        command;
      logic [5:0]  cmd_index;
      logic        app_cmd;
      logic [31:0] argument;
      logic [7:0]  rx_byte;
   } beat_type;

   function automatic kind_type kind_of(input logic [5:0] idx);
      kind_type k;
      unique case (idx)
         6'd8: k = RK_R7;
         6'd12, 6'd28, 6'd29, 6'd38: k = RK_R1B;
         6'd58: k = RK_R3;
         6'd13: k = RK_R2;
         default: k = RK_R1;
      endcase
      return k;
   endfunction

   function automatic logic [6:0] crc7_byte(input logic [6:0] crc_i, input logic [7:0] b);
      logic [6:0] crc;
      logic       fb;
      crc = crc_i;
      for (int k = 7; k >= 0; k--) begin
         fb  = crc[6] ^ b[k];
         crc = {crc[5:0], 1'b0};
         if (fb) crc = crc ^ 7'h09;
      end
      return crc;
   endfunction

endpackage

// ===== design/sdspi_front.sv =====
module sdspi_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sdspi_pkg::beat_type req_beat,
   output logic                q_valid,
   input  logic                q_take,
   output sdspi_pkg::beat_type q_beat
);

   sdspi_pkg::beat_type mem_ff [sdspi_pkg::QUEUE_DEPTH];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_stall = (cnt_ff == 2'(sdspi_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_take;
   assign q_beat    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req_beat;
   end

endmodule

// ===== design/sdspi_back.sv =====
module sdspi_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                crc_enable,
   input  logic [23:0]         retry_limit,
   input  logic                q_valid,
   output logic                q_take,
   input  sdspi_pkg::beat_type q_beat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_tx_valid,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_tx_last,
   output logic                rsp_done_res,
   output logic [1:0]          rsp_outcome,
   output logic [14:0]         rsp_card_status,
   output logic [31:0]         rsp_response_data
);

   sdspi_pkg::phase_type phase_ff, phase_in;
   sdspi_pkg::kind_type  kind_ff, kind_in;
   logic [5:0]  idx_ff, idx_in;
   logic [31:0] arg_ff, arg_in;
   logic        app_ff, app_in;
   logic [23:0] retry_ff, retry_in;
   logic [2:0]  left_ff, left_in;
   logic [7:0]  first_ff, first_in;
   logic [31:0] pay_ff, pay_in;
   logic [2:0]  sent_ff, sent_in;
   logic [6:0]  crc_ff, crc_in;
   logic        o_valid_ff, o_valid_in;
   logic        o_tv_ff, o_tv_in, o_tl_ff, o_tl_in, o_dn_ff, o_dn_in;
   logic [7:0]  o_tb_ff, o_tb_in;
   logic [1:0]  o_oc_ff, o_oc_in;
   logic [14:0] o_st_ff, o_st_in;
   logic [31:0] o_rd_ff, o_rd_in;

   logic        out_free, busy_send, hit;
   logic [5:0]  cur_idx;
   logic [31:0] cur_arg;
   logic [7:0]  fbyte;
   logic [2:0]  need;

   assign out_free  = !o_valid_ff || !rsp_stall;
   assign busy_send = (phase_ff == sdspi_pkg::PH_SEND);
   assign q_take    = out_free && !busy_send;
   assign cur_idx   = app_ff ? 6'd55 : idx_ff;
   assign cur_arg   = app_ff ? 32'd0 : arg_ff;

   always_comb begin
      unique case (sent_ff)
         3'd0: fbyte = {2'b01, cur_idx};
         3'd1: fbyte = cur_arg[31:24];
         3'd2: fbyte = cur_arg[23:16];
         3'd3: fbyte = cur_arg[15:8];
         3'd4: fbyte = cur_arg[7:0];
         default: begin
            if (cur_idx == 6'd0) fbyte = 8'h95;
            else if (cur_idx == 6'd8) fbyte = 8'h87;
            else if (crc_enable) fbyte = {crc_ff, 1'b1};
            else fbyte = 8'h01;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff; kind_in = kind_ff; idx_in = idx_ff; arg_in = arg_ff;
      app_in = app_ff; retry_in = retry_ff; left_in = left_ff; first_in = first_ff;
      pay_in = pay_ff; sent_in = sent_ff; crc_in = crc_ff;
      o_valid_in = o_valid_ff && rsp_stall;
      o_tv_in = o_tv_ff; o_tb_in = o_tb_ff; o_tl_in = o_tl_ff; o_dn_in = o_dn_ff;
      o_oc_in = o_oc_ff; o_st_in = o_st_ff; o_rd_in = o_rd_ff;
      hit = 1'b0; need = 3'd0;
      if (busy_send && out_free) begin
         o_valid_in = 1'b1; o_tv_in = 1'b1; o_tb_in = fbyte;
         o_tl_in = (sent_ff == 3'd5); o_dn_in = 1'b0;
         o_oc_in = '0; o_st_in = '0; o_rd_in = '0;
         crc_in  = sdspi_pkg::crc7_byte(crc_ff, fbyte);
         sent_in = sent_ff + 3'd1;
         if (sent_ff == 3'd5)
            phase_in = (cur_idx == 6'd12) ? sdspi_pkg::PH_SKIP : sdspi_pkg::PH_RESP;
      end else if (q_valid && q_take) begin
         if (!q_beat.command) begin
            if (phase_ff == sdspi_pkg::PH_IDLE) begin
               idx_in = q_beat.cmd_index; app_in = q_beat.app_cmd;
               arg_in = q_beat.argument; retry_in = '0;
               phase_in = sdspi_pkg::PH_READY;
            end
         end else begin
            unique case (phase_ff)
               sdspi_pkg::PH_READY: begin
                  hit = (q_beat.rx_byte == 8'hFF);
                  if (hit && retry_ff < retry_limit) begin
                     kind_in = sdspi_pkg::kind_of(cur_idx);
                     retry_in = '0; sent_in = '0; crc_in = '0;
                     phase_in = sdspi_pkg::PH_SEND;
                  end else begin
                     if (!hit) retry_in = retry_ff + 24'd1;
                     if (retry_in >= retry_limit || hit) begin
                        o_valid_in = 1'b1; o_tv_in = 1'b0; o_tb_in = '0; o_tl_in = 1'b0;
                        o_dn_in = 1'b1; o_oc_in = sdspi_pkg::OC_READY;
                        o_st_in = '0; o_rd_in = '0;
                        phase_in = sdspi_pkg::PH_IDLE; app_in = 1'b0;
                     end
                  end
               end
               sdspi_pkg::PH_SKIP: phase_in = sdspi_pkg::PH_RESP;
               sdspi_pkg::PH_RESP: begin
                  hit = !q_beat.rx_byte[7];
                  if (hit && retry_ff < retry_limit) begin
                     first_in = q_beat.rx_byte; pay_in = '0;
                     if (kind_ff == sdspi_pkg::RK_R2) need = 3'd1;
                     else if (kind_ff == sdspi_pkg::RK_R3 || kind_ff == sdspi_pkg::RK_R7)
                        need = 3'd4;
                     left_in = need;
                     phase_in = sdspi_pkg::PH_EXTRA;
                  end else begin
                     if (!hit) retry_in = retry_ff + 24'd1;
                     if (retry_in >= retry_limit || hit) begin
                        o_valid_in = 1'b1; o_tv_in = 1'b0; o_tb_in = '0; o_tl_in = 1'b0;
                        o_dn_in = 1'b1; o_oc_in = sdspi_pkg::OC_RESP;
                        o_st_in = '0; o_rd_in = '0;
                        phase_in = sdspi_pkg::PH_IDLE; app_in = 1'b0;
                     end
                  end
               end
               sdspi_pkg::PH_EXTRA: begin
                  pay_in  = {pay_ff[23:0], q_beat.rx_byte};
                  left_in = left_ff - 3'd1;
               end
               default: ;
            endcase
            if ((phase_ff == sdspi_pkg::PH_RESP && phase_in == sdspi_pkg::PH_EXTRA
                 && need == 3'd0) ||
                (phase_ff == sdspi_pkg::PH_EXTRA && left_in == 3'd0)) begin
               if (app_ff) begin
                  app_in = 1'b0; retry_in = '0; phase_in = sdspi_pkg::PH_READY;
               end else begin
                  o_valid_in = 1'b1; o_tv_in = 1'b0; o_tb_in = '0; o_tl_in = 1'b0;
                  o_dn_in = 1'b1; o_oc_in = sdspi_pkg::OC_OK;
                  o_st_in = {7'd0, first_in} |
                            ((kind_ff == sdspi_pkg::RK_R2) ? {pay_in[7:0], 7'd0} : 15'd0);
                  o_rd_in = pay_in;
                  phase_in = sdspi_pkg::PH_IDLE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdspi_pkg::PH_IDLE; kind_ff <= sdspi_pkg::RK_R1;
         idx_ff <= '0; arg_ff <= '0; app_ff <= 1'b0; retry_ff <= '0;
         left_ff <= '0; first_ff <= '0; pay_ff <= '0; sent_ff <= '0;
         crc_ff <= '0; o_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; kind_ff <= kind_in; idx_ff <= idx_in; arg_ff <= arg_in;
         app_ff <= app_in; retry_ff <= retry_in; left_ff <= left_in;
         first_ff <= first_in; pay_ff <= pay_in; sent_ff <= sent_in;
         crc_ff <= crc_in; o_valid_ff <= o_valid_in;
      end
      o_tv_ff <= o_tv_in; o_tb_ff <= o_tb_in; o_tl_ff <= o_tl_in; o_dn_ff <= o_dn_in;
      o_oc_ff <= o_oc_in; o_st_ff <= o_st_in; o_rd_ff <= o_rd_in;
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_tx_valid      = o_tv_ff;
   assign rsp_tx_byte       = o_tb_ff;
   assign rsp_tx_last       = o_tl_ff;
   assign rsp_done_res      = o_dn_ff;
   assign rsp_outcome       = o_oc_ff;
   assign rsp_card_status   = o_st_ff;
   assign rsp_response_data = o_rd_ff;

endmodule

// ===== design/sd_spi_command_transaction_top.sv =====
// A received byte that ends a wait passes the queue register; its done beat is then registered.
// A ready byte starts a six-beat frame, one frame beat per cycle while the output is not stalled.
// One input beat per cycle while the queue has room; the sequencer waits while sending or stalled.
// A two-entry queue separates the input side from the sequencer.
// Reset is synchronous and active high: idle, queue empty, crc off, retry limit 65535.
module sd_spi_command_transaction_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [5:0]  req_cmd_index,
   input  logic        req_app_cmd,
   input  logic [31:0] req_argument,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_outcome,
   output logic [14:0] rsp_card_status,
   output logic [31:0] rsp_response_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [23:0] csr_data
);

   logic        crc_en_ff;
   logic [23:0] limit_ff;
   logic        q_valid, q_take;
   sdspi_pkg::beat_type in_beat, q_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_en_ff <= 1'b0;
         limit_ff  <= sdspi_pkg::RETRY_RESET;
      end else if (csr_write) begin
         if (csr_index == sdspi_pkg::CSR_CRC_ENABLE) crc_en_ff <= csr_data[0];
         else limit_ff <= csr_data;
      end
   end

   assign in_beat = '{command: req_command, cmd_index: req_cmd_index,
                      app_cmd: req_app_cmd, argument: req_argument,
                      rx_byte: req_rx_byte};

   sdspi_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_beat(in_beat), .q_valid(q_valid), .q_take(q_take), .q_beat(q_beat)
   );

   sdspi_back u_back (
      .clock(clock), .reset(reset), .crc_enable(crc_en_ff), .retry_limit(limit_ff),
      .q_valid(q_valid), .q_take(q_take), .q_beat(q_beat),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte), .rsp_tx_last(rsp_tx_last),
      .rsp_done_res(rsp_done_res), .rsp_outcome(rsp_outcome),
      .rsp_card_status(rsp_card_status), .rsp_response_data(rsp_response_data)
   );

endmodule

// ===== tb/sv/sd_spi_command_transaction_top_test.sv =====
`timescale 1ns / 100ps

module sd_spi_command_transaction_top_test;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic        done_res;
      logic [1:0]  outcome;
      logic [14:0] card_status;
      logic [31:0] response_data;
   } frame_beat_type;

   typedef struct {
      logic           command;
      logic [5:0]     cmd_index;
      logic           app_cmd;
      logic [31:0]    argument;
      logic [7:0]     rx_byte;
      int             n_exp;
      frame_beat_type exp0;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [5:0]  req_cmd_index = '0;
   logic        req_app_cmd = 1'b0;
   logic [31:0] req_argument = '0;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic        rsp_done_res;
   logic [1:0]  rsp_outcome;
   logic [14:0] rsp_card_status;
   logic [31:0] rsp_response_data;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [23:0] csr_data = '0;

   sd_spi_command_transaction_top dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state.
   logic                 m_crc_on;
   logic [23:0]          m_limit;
   sdspi_pkg::phase_type m_phase;
   logic [5:0]           m_index;
   logic [31:0]          m_arg;
   logic                 m_app;
   logic [23:0]          m_retries;
   sdspi_pkg::kind_type  m_kind;
   logic [2:0]           m_left;
   logic [7:0]           m_first;
   logic [31:0]          m_payload;

   frame_beat_type pending_beats[$];
   frame_beat_type last_pushed;
   int             pushed = 0;
   int             errors = 0;
   int             send_idle = 0;
   int             recv_idle = 0;
   bit             hold_off = 1'b0;
   longint         cycles = 0;

   function automatic frame_beat_type done_beat(logic [1:0] oc, logic [14:0] st,
                                                logic [31:0] rd);
      frame_beat_type b;
      b = '{1'b0, 8'd0, 1'b0, 1'b1, oc, st, rd};
      return b;
   endfunction

   function automatic logic [6:0] crc7_calc(logic [39:0] bits);
      logic [6:0] c;
      logic       fb;
      c = '0;
      for (int i = 39; i >= 0; i--) begin
         fb = c[6] ^ bits[i];
         c  = {c[5:0], 1'b0};
         if (fb) c ^= 7'h09;
      end
      return c;
   endfunction

   function automatic sdspi_pkg::kind_type response_type(logic [5:0] idx);
      case (idx)
         6'd8: return sdspi_pkg::RK_R7;
         6'd12, 6'd28, 6'd29, 6'd38: return sdspi_pkg::RK_R1B;
         6'd58: return sdspi_pkg::RK_R3;
         6'd13: return sdspi_pkg::RK_R2;
         default: return sdspi_pkg::RK_R1;
      endcase
   endfunction

   task automatic push_expected(frame_beat_type b);
      pending_beats.push_back(b);
      last_pushed = b;
      pushed++;
   endtask

   task automatic finish_transaction(logic [1:0] oc, logic [14:0] st, logic [31:0] rd);
      push_expected(done_beat(oc, st, rd));
      m_phase = sdspi_pkg::PH_IDLE;
      m_app = 1'b0;
   endtask

   task automatic response_finished();
      logic [14:0] st;
      if (m_app) begin
         m_app = 1'b0;
         m_retries = '0;
         m_phase = sdspi_pkg::PH_READY;
      end else begin
         st = {7'd0, m_first};
         if (m_kind == sdspi_pkg::RK_R2) st |= {m_payload[7:0], 7'd0};
         finish_transaction(sdspi_pkg::OC_OK, st, m_payload);
      end
   endtask

   task automatic predict_beat(logic cmd, logic [5:0] idx, logic app, logic [31:0] arg,
                               logic [7:0] rx);
      logic [5:0]     ci;
      logic [31:0]    ca;
      logic [7:0]     f[6];
      frame_beat_type b;
      if (!cmd) begin
         if (m_phase == sdspi_pkg::PH_IDLE) begin
            m_index = idx;
            m_app = app;
            m_arg = arg;
            m_retries = '0;
            m_phase = sdspi_pkg::PH_READY;
         end
      end else begin
         case (m_phase)
            sdspi_pkg::PH_READY: begin
               if (rx == 8'hFF && m_retries < m_limit) begin
                  ci = m_app ? 6'd55 : m_index;
                  ca = m_app ? 32'd0 : m_arg;
                  f[0] = {2'b01, ci};
                  f[1] = ca[31:24];
                  f[2] = ca[23:16];
                  f[3] = ca[15:8];
                  f[4] = ca[7:0];
                  if (ci == 6'd0) f[5] = 8'h95;
                  else if (ci == 6'd8) f[5] = 8'h87;
                  else if (m_crc_on) f[5] = {crc7_calc({f[0], ca}), 1'b1};
                  else f[5] = 8'h01;
                  for (int k = 0; k < 6; k++) begin
                     b = '{1'b1, f[k], k == 5, 1'b0, 2'd0, 15'd0, 32'd0};
                     push_expected(b);
                  end
                  m_kind = response_type(ci);
                  m_retries = '0;
                  m_phase = (ci == 6'd12) ? sdspi_pkg::PH_SKIP : sdspi_pkg::PH_RESP;
               end else begin
                  if (rx != 8'hFF) m_retries++;
                  if (m_retries >= m_limit || rx == 8'hFF)
                     finish_transaction(sdspi_pkg::OC_READY, 15'd0, 32'd0);
               end
            end
            sdspi_pkg::PH_SKIP: m_phase = sdspi_pkg::PH_RESP;
            sdspi_pkg::PH_RESP: begin
               if (!rx[7] && m_retries < m_limit) begin
                  m_first = rx;
                  m_payload = '0;
                  if (m_kind == sdspi_pkg::RK_R2) m_left = 3'd1;
                  else if (m_kind == sdspi_pkg::RK_R3 || m_kind == sdspi_pkg::RK_R7)
                     m_left = 3'd4;
                  else m_left = 3'd0;
                  if (m_left == 3'd0) response_finished();
                  else m_phase = sdspi_pkg::PH_EXTRA;
               end else begin
                  if (rx[7]) m_retries++;
                  if (m_retries >= m_limit || !rx[7])
                     finish_transaction(sdspi_pkg::OC_RESP, 15'd0, 32'd0);
               end
            end
            sdspi_pkg::PH_EXTRA: begin
               m_payload = {m_payload[23:0], rx};
               m_left = m_left - 3'd1;
               if (m_left == 3'd0) response_finished();
            end
            default: ;
         endcase
      end
   endtask

   task automatic send_beat(logic cmd, logic [5:0] idx, logic app, logic [31:0] arg,
                            logic [7:0] rx);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_cmd_index <= idx;
      req_app_cmd <= app;
      req_argument <= arg;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(cmd, idx, app, arg, rx);
   endtask

   task automatic write_csr(logic idx, logic [23:0] val);
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == sdspi_pkg::CSR_CRC_ENABLE) m_crc_on = val[0];
      else m_limit = val;
   endtask

   task automatic random_transaction();
      logic [5:0] idx;
      int         pick;
      pick = $urandom_range(9);
      case (pick)
         0: idx = 6'd8;
         1: idx = 6'd12;
         2: idx = 6'd58;
         3: idx = 6'd13;
         4: idx = 6'd0;
         5: idx = 6'd38;
         default: idx = 6'($urandom);
      endcase
      send_beat(1'b0, idx, $urandom_range(3) == 0, $urandom, 8'($urandom));
      for (int n = $urandom_range(12, 3); n > 0; n--) begin
         pick = $urandom_range(9);
         if (m_phase == sdspi_pkg::PH_READY)
            send_beat(1'b1, 6'($urandom), 1'($urandom),
                      $urandom, pick < 6 ? 8'hFF : 8'($urandom));
         else if (m_phase == sdspi_pkg::PH_RESP)
            send_beat(1'b1, 6'($urandom), 1'($urandom),
                      $urandom, pick < 6 ? {1'b0, 7'($urandom)} : 8'($urandom));
         else if (pick == 0)
            send_beat(1'b0, 6'($urandom), 1'($urandom), $urandom, 8'($urandom));
         else
            send_beat(1'b1, 6'($urandom), 1'($urandom), $urandom, 8'($urandom));
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= recv_idle > 0 && $urandom_range(99) < recv_idle;
   end

   always @(posedge clock) begin
      frame_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat tx %h/%h", $time, rsp_tx_byte, rsp_done_res);
            errors++;
         end else begin
            e = pending_beats.pop_front();
            if ({rsp_tx_valid, rsp_tx_byte, rsp_tx_last, rsp_done_res, rsp_outcome,
                 rsp_card_status, rsp_response_data} !==
                {e.tx_valid, e.tx_byte, e.tx_last, e.done_res, e.outcome,
                 e.card_status, e.response_data}) begin
               $display("%0t: expected %h %h %h %h %h %h %h actual %h %h %h %h %h %h %h",
                        $time, e.tx_valid, e.tx_byte, e.tx_last, e.done_res, e.outcome,
                        e.card_status, e.response_data, rsp_tx_valid, rsp_tx_byte,
                        rsp_tx_last, rsp_done_res, rsp_outcome, rsp_card_status,
                        rsp_response_data);
               errors++;
            end
         end
      end
   end

   stim_row_type rows[$];

   task automatic add_row(logic c, logic [5:0] i, logic a, logic [31:0] g, logic [7:0] r,
                          int n = -1, frame_beat_type e = '{0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{c, i, a, g, r, n, e});
   endtask

   initial begin
      frame_beat_type got;
      int             base_count;
      m_crc_on = 1'b0;
      m_limit = 24'd65535;
      m_phase = sdspi_pkg::PH_IDLE;
      m_index = '0;
      m_arg = '0;
      m_app = 1'b0;
      m_retries = '0;
      m_kind = sdspi_pkg::RK_R1;
      m_left = '0;
      m_first = '0;
      m_payload = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte while idle, CMD0, busy issue, CMD8 with R7, CMD13 R2, CMD12 skip,
      // app command, ready and response expiry.
      add_row(1, 0, 0, 0, 8'hFF, 0);
      add_row(0, 0, 0, 32'h0, 8'h00);
      add_row(0, 6'd63, 1, 32'hFFFFFFFF, 8'hFF, 0);
      add_row(1, 0, 0, 0, 8'hFF);
      add_row(1, 0, 0, 0, 8'h01, 1, done_beat(sdspi_pkg::OC_OK, 15'h01, 32'd0));
      add_row(0, 6'd8, 0, 32'h000001AA, 8'h00);
      add_row(1, 0, 0, 0, 8'hFF);
      add_row(1, 0, 0, 0, 8'hFF);
      add_row(1, 0, 0, 0, 8'h01);
      add_row(1, 0, 0, 0, 8'h00);
      add_row(1, 0, 0, 0, 8'h00);
      add_row(1, 0, 0, 0, 8'h01);
      add_row(1, 0, 0, 0, 8'hAA, 1, done_beat(sdspi_pkg::OC_OK, 15'h01, 32'h000001AA));
      add_row(0, 6'd13, 0, 32'hFFFFFFFF, 8'h00);
      add_row(1, 0, 0, 0, 8'hFF);
      add_row(1, 0, 0, 0, 8'h7F);
      add_row(1, 0, 0, 0, 8'hFF);
      add_row(0, 6'd12, 1, 32'h12345678, 8'h00);
      add_row(1, 0, 0, 0, 8'hFF);
      add_row(1, 0, 0, 0, 8'h00);
      add_row(1, 0, 0, 0, 8'hFF);
      add_row(1, 0, 0, 0, 8'hFF);
      add_row(1, 0, 0, 0, 8'h00);
      add_row(1, 0, 0, 0, 8'h05);
      foreach (rows[k]) begin
         base_count = pushed;
         send_beat(rows[k].command, rows[k].cmd_index, rows[k].app_cmd, rows[k].argument,
                   rows[k].rx_byte);
         if (rows[k].n_exp >= 0 && pushed - base_count != rows[k].n_exp) begin
            $display("%0t: expected %0d beats actual %0d", $time, rows[k].n_exp,
                     pushed - base_count);
            errors++;
         end
         if (rows[k].n_exp == 1 && pushed > base_count) begin
            got = last_pushed;
            if (got !== rows[k].exp0) begin
               $display("%0t: expected done %h/%h actual %h/%h", $time,
                        rows[k].exp0.outcome, rows[k].exp0.card_status,
                        got.outcome, got.card_status);
               errors++;
            end
         end
      end

      write_csr(sdspi_pkg::CSR_RETRY_LIMIT, 24'd1);
      write_csr(sdspi_pkg::CSR_CRC_ENABLE, 24'd1);
      send_beat(0, 6'd17, 0, 32'hA5A5A5A5, 0);
      send_beat(1, 0, 0, 0, 8'h00);
      send_beat(0, 6'd17, 0, 32'h0, 0);
      send_beat(1, 0, 0, 0, 8'hFF);
      send_beat(1, 0, 0, 0, 8'h80);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 67; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 67; end
            3: begin send_idle = 17; recv_idle = 17; end
            4: begin send_idle = 0;  recv_idle = 0;  end
            default: begin send_idle = 17; recv_idle = 67; end
         endcase
         write_csr(sdspi_pkg::CSR_CRC_ENABLE, 24'($urandom_range(1)));
         write_csr(sdspi_pkg::CSR_RETRY_LIMIT,
                   ph == 4 ? 24'hFFFFFF : 24'($urandom_range(6, 1)));
         if (ph == 4) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (150) @(posedge clock);
                  hold_off = 1'b0;
               end
               for (int t = 0; t < 6; t++) random_transaction();
            join
         end else begin
            for (int t = 0; t < 6; t++) random_transaction();
         end
      end

      send_idle = 0;
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
